### rtl/touch_debounce_press_timer_top_defines.svh
// assertion macros for the touch debounce press timer
`ifndef TOUCH_DEBOUNCE_PRESS_TIMER_TOP_DEFINES_SVH
`define TOUCH_DEBOUNCE_PRESS_TIMER_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define TDPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdpt assertion failed");

// consequent checked from the next cycle on
`define TDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("tdpt assertion failed");

`endif

### rtl/tdpt_pkg.sv
package tdpt_pkg;

  localparam int LimitW = 8;
  localparam int TicksW = 16;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 16;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdFetch = 1'b1;

  localparam logic [CfgIdxW-1:0] RegDebounceLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] RegShortPress = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLongPress = 8'd2;
  localparam logic [CfgIdxW-1:0] RegPressCap = 8'd3;

  localparam logic [LimitW-1:0] DebounceLimitRst = 8'd50;
  localparam logic [TicksW-1:0] ShortPressRst = 16'd500;
  localparam logic [TicksW-1:0] LongPressRst = 16'd2000;
  localparam logic [TicksW-1:0] PressCapRst = 16'd60000;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_EDGE  = 2'd1,
    EVT_SHORT = 2'd2,
    EVT_LONG  = 2'd3
  } evt_t;

  typedef struct packed {
    logic cmd;
    logic raw_level;
  } in_t;

  typedef struct packed {
    evt_t              event_code;
    logic              pressed_level;
    logic [TicksW-1:0] press_duration;
  } out_t;

  typedef struct packed {
    logic [LimitW-1:0] debounce_limit;
    logic [TicksW-1:0] short_press_ticks;
    logic [TicksW-1:0] long_press_ticks;
    logic [TicksW-1:0] press_cap_ticks;
  } cfg_t;

endpackage

### rtl/tdpt_cfg_regs.sv
module tdpt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tdpt_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [tdpt_pkg::CfgDataW-1:0] wr_data,
  output tdpt_pkg::cfg_t                 cfg
);

  tdpt_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit    <= tdpt_pkg::DebounceLimitRst;
      cfg_r.short_press_ticks <= tdpt_pkg::ShortPressRst;
      cfg_r.long_press_ticks  <= tdpt_pkg::LongPressRst;
      cfg_r.press_cap_ticks   <= tdpt_pkg::PressCapRst;
    end else if (wr_en) begin
      case (wr_index)
        tdpt_pkg::RegDebounceLimit: begin
          cfg_r.debounce_limit <= wr_data[tdpt_pkg::LimitW-1:0];
        end
        tdpt_pkg::RegShortPress: begin
          cfg_r.short_press_ticks <= wr_data[tdpt_pkg::TicksW-1:0];
        end
        tdpt_pkg::RegLongPress: begin
          cfg_r.long_press_ticks <= wr_data[tdpt_pkg::TicksW-1:0];
        end
        tdpt_pkg::RegPressCap: begin
          cfg_r.press_cap_ticks <= wr_data[tdpt_pkg::TicksW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/tdpt_core.sv
module tdpt_core #(
  parameter int DEBOUNCE_WIDTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  tdpt_pkg::in_t  item,
  input  tdpt_pkg::cfg_t cfg,
  output tdpt_pkg::out_t result
);

  localparam int LimW = (DEBOUNCE_WIDTH > tdpt_pkg::LimitW) ? DEBOUNCE_WIDTH : tdpt_pkg::LimitW;
  localparam logic [LimW-1:0] CntMax = LimW'((1 << DEBOUNCE_WIDTH) - 1);

  logic [DEBOUNCE_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                        lvl_r, lvl_nxt;
  logic [tdpt_pkg::TicksW-1:0] press_r, press_nxt;
  tdpt_pkg::evt_t              evt_r, evt_nxt;

  logic [LimW-1:0]           lim_ext;
  logic [LimW-1:0]           lim_eff;
  logic [DEBOUNCE_WIDTH-1:0] lim;

  // effective limit clipped to the integrator range
  always_comb begin
    lim_ext = LimW'(cfg.debounce_limit);
    lim_eff = (lim_ext < CntMax) ? lim_ext : CntMax;
    lim     = lim_eff[DEBOUNCE_WIDTH-1:0];
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    press_nxt = press_r;
    evt_nxt   = evt_r;
    result.event_code = tdpt_pkg::EVT_NONE;
    if (item.cmd == tdpt_pkg::CmdTick) begin
      if (item.raw_level) begin
        if (cnt_r < lim) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cnt_nxt >= lim && !lvl_r) begin
          lvl_nxt = 1'b1;
          evt_nxt = tdpt_pkg::EVT_EDGE;
        end
      end else begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        if (cnt_nxt == '0 && lvl_r) begin
          lvl_nxt   = 1'b0;
          press_nxt = '0;
        end
      end
      if (lvl_nxt) begin
        if (press_nxt < cfg.press_cap_ticks) begin
          press_nxt = press_nxt + 1'b1;
        end
        if (press_nxt == cfg.short_press_ticks) begin
          evt_nxt = tdpt_pkg::EVT_SHORT;
        end
        if (press_nxt == cfg.long_press_ticks) begin
          evt_nxt = tdpt_pkg::EVT_LONG;
        end
      end
    end else begin
      result.event_code = evt_r;
      evt_nxt = tdpt_pkg::EVT_NONE;
    end
    result.pressed_level  = lvl_nxt;
    result.press_duration = lvl_nxt ? press_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      lvl_r   <= 1'b0;
      press_r <= '0;
      evt_r   <= tdpt_pkg::EVT_NONE;
    end else if (advance) begin
      cnt_r   <= cnt_nxt;
      lvl_r   <= lvl_nxt;
      press_r <= press_nxt;
      evt_r   <= evt_nxt;
    end
  end

endmodule

### rtl/touch_debounce_press_timer_top.sv
// Touch debounce with press timer. Each input transfer is either a one-millisecond
// tick carrying the raw touch level or a fetch of the pending event, and each gives
// exactly one result. The block takes one item per clock cycle while the output side
// is not stalled. An item transferred in is held in the input register, moves into
// the result register as the pipeline advances (out_valid rises then) and is
// transferred out from the result register. The debounce state is updated as the
// item moves into the result register. A stalled output holds the pipeline, and the
// input side keeps accepting until both registers are full. Configuration writes are
// always accepted once cfg_ready has risen (cfg_ready is low in reset and in the
// cycle after it) and go to the registers debounce_limit, short_press_ticks,
// long_press_ticks and press_cap_ticks at indexes 0 to 3; other indexes are ignored.
// DEBOUNCE_WIDTH sets the width of the integrator, and the debounce limit is clipped
// to its range.
module touch_debounce_press_timer_top #(
  parameter int DEBOUNCE_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tdpt_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tdpt_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tdpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tdpt_pkg::CfgDataW-1:0] cfg_data
);

  tdpt_pkg::in_t  in_r;
  logic           in_vld_r;
  tdpt_pkg::out_t out_r;
  logic           out_vld_r;
  logic           cfg_ready_r;
  tdpt_pkg::out_t result;
  tdpt_pkg::cfg_t cfg;
  logic           advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      cfg_ready_r <= 1'b0;
    end else begin
      cfg_ready_r <= 1'b1;
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  tdpt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready_r),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tdpt_core #(
    .DEBOUNCE_WIDTH(DEBOUNCE_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_r),
    .cfg     (cfg),
    .result  (result)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = cfg_ready_r;

endmodule

### rtl/tdpt_checker.sv
`include "touch_debounce_press_timer_top_defines.svh"

module tdpt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tdpt_pkg::out_t out_data
);

  // stalled result holds
  `TDPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // an accepted transfer is followed by a valid result after the input and result registers
  `TDPT_ASSERT_NEXT(a_latency, in_valid && in_ready, ##1 out_valid)

  // input back-pressure only when the output is stalled
  `TDPT_ASSERT_NOW(a_backpressure, !in_ready, out_valid && !out_ready)

  // released level reports no press time
  `TDPT_ASSERT_NOW(a_released_zero, out_valid && !out_data.pressed_level,
                   out_data.press_duration == '0)

endmodule

bind touch_debounce_press_timer_top tdpt_checker u_tdpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
